// ===== design/pse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

  // Input item codes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_PPK    = 2'd0;
  localparam logic [1:0] CFG_CLK_HZ = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;
  localparam logic [1:0] CFG_SIM    = 2'd3;

  localparam int unsigned CFG_W = 27;

  // Configuration reset values
  localparam logic [15:0]      PPK_RESET    = 16'd3600;
  localparam logic [CFG_W-1:0] CLK_HZ_RESET = 27'd25000000;
  localparam logic [15:0]      THRESH_RESET = 16'd1000;

  // History and averaging
  localparam int unsigned HIST_DEPTH    = 5;
  localparam int unsigned AVG_LEN       = (HIST_DEPTH < 5) ? HIST_DEPTH : 5;
  localparam int unsigned SUM_W         = 16 + $clog2(AVG_LEN);
  localparam int unsigned TICKS_PER_SEC = 5;
  localparam int unsigned PHASE_W       = 3;

  // Average by reciprocal multiplication, exact for every sum of AVG_LEN samples
  localparam int unsigned AVG_SHIFT  = 21;
  localparam int unsigned AVG_RECIP  = ((1 << AVG_SHIFT) + AVG_LEN - 1) / AVG_LEN;
  localparam int unsigned AVG_PROD_W = AVG_SHIFT + 16;

  // Speed arithmetic
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned FREQ_W      = 9;
  localparam int unsigned DIV_W       = 32;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int unsigned COUNT_SCALE = 5 * 3600;
  localparam int unsigned SPEED_SCALE = 3600;
  localparam int unsigned LOW_SCALE   = 10 * 3600;
  localparam int unsigned JUMP_LIMIT  = 150;
  localparam int unsigned SIM_FREQ    = 116;
  localparam logic [CNT_W-1:0] CNT_SAT = {1'b1, {(CNT_W-1){1'b0}}};

  // Command queue
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [15:0]      ppk;
    logic [CFG_W-1:0] clk_hz;
    logic [15:0]      thresh;
    logic             sim;
  } cfg_t;

  // One tick, as classified by the front end
  typedef struct packed {
    logic             use_count;
    logic [CNT_W-1:0] count;
    logic [31:0]      period;
    logic [7:0]       sw;
    logic [31:0]      total;
  } tick_cmd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [7:0]  speed_kmh;
    logic [7:0]  switch_byte;
    logic [15:0] low_speed_tenths;
    logic [15:0] second_speed;
    logic        second_updated;
    logic [31:0] total_pulses;
  } result_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_START,
    BK_FREQ,
    BK_FILT,
    BK_LOW_GO,
    BK_LOW,
    BK_SPD,
    BK_COMMIT,
    BK_AVG_GO,
    BK_OUT
  } back_state_e;

endpackage

`default_nettype wire

// ===== design/pse_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pse_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  pse_pkg::tick_cmd_t   push_data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire                  pop_i,
  output pse_pkg::tick_cmd_t   pop_data_o
);

  pse_pkg::tick_cmd_t                  entry_q [pse_pkg::FIFO_DEPTH];
  logic [pse_pkg::FIFO_AW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [pse_pkg::FIFO_AW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [pse_pkg::FIFO_AW:0]           count_q, count_d;
  logic                                do_push, do_pop;

  assign full_o     = (count_q == (pse_pkg::FIFO_AW + 1)'(pse_pkg::FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = do_push ? pse_pkg::FIFO_AW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? pse_pkg::FIFO_AW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/pse_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pse_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  pse_pkg::cfg_t        cfg_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire                  op_i,
  input  wire  [31:0]          period_i,
  input  wire                  brake_i,
  input  wire                  left_turn_i,
  input  wire                  right_turn_i,
  input  wire                  high_beam_i,
  input  wire                  low_beam_i,
  input  wire                  fifo_full_i,
  output logic                 push_o,
  output pse_pkg::tick_cmd_t   cmd_o
);

  logic [31:0] window_q, window_d;
  logic [31:0] total_q, total_d;
  logic [31:0] period_q, period_d;
  logic        accept;
  logic        use_count;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign use_count  = (window_q >= 32'(cfg_i.thresh));

  // Classify the tick and snapshot what the back end needs
  always_comb begin
    cmd_o.use_count = use_count;
    cmd_o.count     = (window_q[31:16] != '0) ? pse_pkg::CNT_SAT
                                              : pse_pkg::CNT_W'(window_q[15:0]);
    cmd_o.period    = period_q;
    cmd_o.sw        = {brake_i, left_turn_i, right_turn_i, high_beam_i, low_beam_i, 3'b000};
    cmd_o.total     = total_q;
    push_o          = accept && (op_i == pse_pkg::OP_TICK);
  end

  // Count edges and hold the last period; a tick clears the edge window, and the period only by the period method
  always_comb begin
    window_d = window_q;
    total_d  = total_q;
    period_d = period_q;
    if (accept) begin
      if (op_i == pse_pkg::OP_EDGE) begin
        window_d = window_q + 1'b1;
        total_d  = total_q + 1'b1;
        period_d = period_i;
      end else begin
        window_d = '0;
        if (!use_count) begin
          period_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      total_q  <= '0;
      period_q <= '0;
    end else begin
      window_q <= window_d;
      total_q  <= total_d;
      period_q <= period_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pse_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pse_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pse_pkg::div_req_t   req_i,
  output pse_pkg::div_rsp_t   rsp_o
);

  logic [pse_pkg::DIV_W-1:0]     quot_q, quot_d;
  logic [pse_pkg::DIV_W-1:0]     rem_q, rem_d;
  logic [pse_pkg::DIV_W-1:0]     den_q, den_d;
  logic [pse_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [pse_pkg::DIV_W:0]       trial;
  logic [pse_pkg::DIV_W:0]       diff;

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  // One restoring step a cycle, numerator shifts out of the quotient register
  always_comb begin
    trial  = {rem_q, quot_q[pse_pkg::DIV_W-1]};
    diff   = trial - {1'b0, den_q};
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (!diff[pse_pkg::DIV_W]) begin
        rem_d  = diff[pse_pkg::DIV_W-1:0];
        quot_d = {quot_q[pse_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[pse_pkg::DIV_W-1:0];
        quot_d = {quot_q[pse_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == pse_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = pse_pkg::DIV_CNT_W'(pse_pkg::DIV_W);
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

endmodule

`default_nettype wire

// ===== design/pse_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pse_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  pse_pkg::cfg_t        cfg_i,
  input  wire                  fifo_valid_i,
  input  pse_pkg::tick_cmd_t   fifo_data_i,
  output logic                 pop_o,
  output pse_pkg::div_req_t    div_req_o,
  input  pse_pkg::div_rsp_t    div_rsp_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output pse_pkg::result_t     res_o
);

  pse_pkg::back_state_e          state_q, state_d;
  pse_pkg::tick_cmd_t            cmd_q, cmd_d;
  logic [pse_pkg::CFG_W-1:0]     freq_q, freq_d;
  logic [pse_pkg::FREQ_W-1:0]    freqf_q, freqf_d;
  logic [15:0]                   low_new_q, low_new_d;
  logic [7:0]                    spd_new_q, spd_new_d;
  logic [7:0]                    speed_q, speed_d;
  logic [15:0]                   lhist_q [pse_pkg::AVG_LEN];
  logic [15:0]                   lhist_d [pse_pkg::AVG_LEN];
  logic [pse_pkg::SUM_W-1:0]     sum_q, sum_d;
  logic [pse_pkg::PHASE_W-1:0]   phase_q, phase_d;
  logic [15:0]                   avg_q, avg_d;
  logic                          upd_q, upd_d;
  logic                          out_valid_q, out_valid_d;
  pse_pkg::result_t              res_q, res_d;
  logic [pse_pkg::DIV_W-1:0]     ppk_nz;
  logic [pse_pkg::FREQ_W-1:0]    jump_cap;
  logic [pse_pkg::AVG_PROD_W-1:0] avg_prod;

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign ppk_nz      = (cfg_i.ppk == '0) ? pse_pkg::DIV_W'(1) : pse_pkg::DIV_W'(cfg_i.ppk);
  assign jump_cap    = pse_pkg::FREQ_W'(speed_q) + pse_pkg::FREQ_W'(pse_pkg::JUMP_LIMIT);

  // Scale the running sum by the reciprocal of the sample count
  assign avg_prod    = pse_pkg::AVG_PROD_W'(sum_q) * pse_pkg::AVG_PROD_W'(pse_pkg::AVG_RECIP);

  // Sequence one tick through the shared divider
  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    freq_d        = freq_q;
    freqf_d       = freqf_q;
    low_new_d     = low_new_q;
    spd_new_d     = spd_new_q;
    speed_d       = speed_q;
    lhist_d       = lhist_q;
    sum_d         = sum_q;
    phase_d       = phase_q;
    avg_d         = avg_q;
    upd_d         = upd_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    pop_o         = 1'b0;
    div_req_o     = '0;

    case (state_q)
      pse_pkg::BK_IDLE: begin
        if (fifo_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = fifo_data_i;
          state_d = pse_pkg::BK_START;
        end
      end
      pse_pkg::BK_START: begin
        if (cmd_q.use_count) begin
          div_req_o.start = 1'b1;
          div_req_o.num   = pse_pkg::DIV_W'(cmd_q.count) *
                            pse_pkg::DIV_W'(pse_pkg::COUNT_SCALE);
          div_req_o.den   = ppk_nz;
          state_d         = pse_pkg::BK_SPD;
        end else if (cmd_q.period == '0) begin
          freq_d  = '0;
          state_d = pse_pkg::BK_FILT;
        end else begin
          div_req_o.start = 1'b1;
          div_req_o.num   = pse_pkg::DIV_W'(cfg_i.clk_hz);
          div_req_o.den   = cmd_q.period;
          state_d         = pse_pkg::BK_FREQ;
        end
      end
      pse_pkg::BK_FREQ: begin
        if (div_rsp_i.done) begin
          freq_d  = div_rsp_i.quot[pse_pkg::CFG_W-1:0];
          state_d = pse_pkg::BK_FILT;
        end
      end
      pse_pkg::BK_FILT: begin
        // Hold the previous speed on an implausible jump
        if (freq_q > pse_pkg::CFG_W'(jump_cap)) begin
          freqf_d = pse_pkg::FREQ_W'(speed_q);
        end else begin
          freqf_d = freq_q[pse_pkg::FREQ_W-1:0];
        end
        if (cfg_i.sim) begin
          freqf_d = pse_pkg::FREQ_W'(pse_pkg::SIM_FREQ);
        end
        state_d = pse_pkg::BK_LOW_GO;
      end
      pse_pkg::BK_LOW_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = pse_pkg::DIV_W'(freqf_q) * pse_pkg::DIV_W'(pse_pkg::LOW_SCALE);
        div_req_o.den   = ppk_nz;
        state_d         = pse_pkg::BK_LOW;
      end
      pse_pkg::BK_LOW: begin
        if (div_rsp_i.done) begin
          low_new_d = (div_rsp_i.quot[pse_pkg::DIV_W-1:16] != '0) ? 16'hFFFF
                                                                  : div_rsp_i.quot[15:0];
          div_req_o.start = 1'b1;
          div_req_o.num   = pse_pkg::DIV_W'(freqf_q) *
                            pse_pkg::DIV_W'(pse_pkg::SPEED_SCALE);
          div_req_o.den   = ppk_nz;
          state_d         = pse_pkg::BK_SPD;
        end
      end
      pse_pkg::BK_SPD: begin
        if (div_rsp_i.done) begin
          spd_new_d = (div_rsp_i.quot[pse_pkg::DIV_W-1:8] != '0) ? 8'hFF
                                                                 : div_rsp_i.quot[7:0];
          state_d   = pse_pkg::BK_COMMIT;
        end
      end
      pse_pkg::BK_COMMIT: begin
        speed_d = spd_new_q;
        // Shift the low-speed samples and keep the running sum in step
        if (!cmd_q.use_count) begin
          for (int i = pse_pkg::AVG_LEN - 1; i > 0; i--) begin
            lhist_d[i] = lhist_q[i-1];
          end
          lhist_d[0] = low_new_q;
          sum_d = sum_q + pse_pkg::SUM_W'(low_new_q)
                        - pse_pkg::SUM_W'(lhist_q[pse_pkg::AVG_LEN-1]);
        end
        if (phase_q == pse_pkg::PHASE_W'(pse_pkg::TICKS_PER_SEC - 1)) begin
          phase_d = '0;
          upd_d   = 1'b1;
          state_d = pse_pkg::BK_AVG_GO;
        end else begin
          phase_d = phase_q + 1'b1;
          upd_d   = 1'b0;
          state_d = pse_pkg::BK_OUT;
        end
      end
      pse_pkg::BK_AVG_GO: begin
        avg_d   = avg_prod[pse_pkg::AVG_SHIFT +: 16];
        state_d = pse_pkg::BK_OUT;
      end
      pse_pkg::BK_OUT: begin
        // Load the result beat once the output register is free
        if (!out_valid_q || out_ready_i) begin
          res_d.speed_kmh        = speed_q;
          res_d.switch_byte      = cmd_q.sw;
          res_d.low_speed_tenths = lhist_q[0];
          res_d.second_speed     = avg_q;
          res_d.second_updated   = upd_q;
          res_d.total_pulses     = cmd_q.total;
          out_valid_d            = 1'b1;
          state_d                = pse_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = pse_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pse_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      speed_q     <= '0;
      sum_q       <= '0;
      phase_q     <= '0;
      avg_q       <= '0;
      for (int i = 0; i < pse_pkg::AVG_LEN; i++) begin
        lhist_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      speed_q     <= speed_d;
      sum_q       <= sum_d;
      phase_q     <= phase_d;
      avg_q       <= avg_d;
      lhist_q     <= lhist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    freq_q    <= freq_d;
    freqf_q   <= freqf_d;
    low_new_q <= low_new_d;
    spd_new_q <= spd_new_d;
    upd_q     <= upd_d;
    res_q     <= res_d;
  end

endmodule

`default_nettype wire

// ===== design/pulse_speed_estimator.sv =====
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  op, period, brake, turn and beam flags
// out       output     out_valid_o / out_ready_i speed, switches, low speed, average, total
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// An edge beat gives no result. A tick is worked with one division by the count
// method and with three by the period method (two for a zero period), and every
// fifth tick also updates the seconds average; every division runs through one
// shared 32-step serial divider. A two-entry tick queue lets edges and ticks keep
// arriving while the back end works; input stalls only when that queue is full.
// Reset is asynchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pulse_speed_estimator (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire  [1:0]                 cfg_idx_i,
  input  wire  [pse_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        op_i,
  input  wire  [31:0]                period_i,
  input  wire                        brake_i,
  input  wire                        left_turn_i,
  input  wire                        right_turn_i,
  input  wire                        high_beam_i,
  input  wire                        low_beam_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [7:0]                 speed_kmh_o,
  output logic [7:0]                 switch_byte_o,
  output logic [15:0]                low_speed_tenths_o,
  output logic [15:0]                second_speed_o,
  output logic                       second_updated_o,
  output logic [31:0]                total_pulses_o
);

  pse_pkg::cfg_t       cfg_q, cfg_d;
  pse_pkg::tick_cmd_t  push_cmd, pop_cmd;
  pse_pkg::div_req_t   div_req;
  pse_pkg::div_rsp_t   div_rsp;
  pse_pkg::result_t    res;
  logic                fifo_full, fifo_valid, push, pop;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pse_pkg::CFG_PPK:    cfg_d.ppk    = cfg_wdata_i[15:0];
        pse_pkg::CFG_CLK_HZ: cfg_d.clk_hz = cfg_wdata_i;
        pse_pkg::CFG_THRESH: cfg_d.thresh = cfg_wdata_i[15:0];
        pse_pkg::CFG_SIM:    cfg_d.sim    = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ppk    <= pse_pkg::PPK_RESET;
      cfg_q.clk_hz <= pse_pkg::CLK_HZ_RESET;
      cfg_q.thresh <= pse_pkg::THRESH_RESET;
      cfg_q.sim    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .period_i     (period_i),
    .brake_i      (brake_i),
    .left_turn_i  (left_turn_i),
    .right_turn_i (right_turn_i),
    .high_beam_i  (high_beam_i),
    .low_beam_i   (low_beam_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  pse_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd)
  );

  pse_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (pop_cmd),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign speed_kmh_o        = res.speed_kmh;
  assign switch_byte_o      = res.switch_byte;
  assign low_speed_tenths_o = res.low_speed_tenths;
  assign second_speed_o     = res.second_speed;
  assign second_updated_o   = res.second_updated;
  assign total_pulses_o     = res.total_pulses;

endmodule

`default_nettype wire

// ===== design/pse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pse_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        out_valid_o,
  input wire                        out_ready_i,
  input wire [7:0]                  speed_kmh_o,
  input wire [7:0]                  switch_byte_o,
  input wire [15:0]                 low_speed_tenths_o,
  input wire [15:0]                 second_speed_o,
  input wire                        second_updated_o,
  input wire [31:0]                 total_pulses_o
);

  // No result beat is offered while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // Unused switch bits stay clear in every result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (switch_byte_o[2:0] == 3'b000))
    else $error("switch byte low bits set");

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(speed_kmh_o) && $stable(switch_byte_o) && $stable(low_speed_tenths_o) &&
      $stable(second_speed_o) && $stable(second_updated_o) && $stable(total_pulses_o))
    else $error("result payload changed while stalled");

endmodule

bind pulse_speed_estimator pse_checker u_pse_checker (.*);

`default_nettype wire
